// File: src/pss_pkg.sv
// Shared types and constants for the positional sequence store.
`timescale 1ns / 1ps

package pss_pkg;

    // Storage size and field widths.
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int CMD_W    = 2;
    localparam int DATA_W   = 32;
    localparam int ST_W     = 2;

    // Read-back tree: cells are gathered in groups of GRP_SIZE.
    localparam int GRP_SIZE = 8;
    localparam int GRP_NUM  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

// File: src/pss_cell.sv
// One storage cell of the chain: holds one entry and shifts with its neighbors.
`timescale 1ns / 1ps

module pss_cell (
    input  logic                         i_clk,
    input  pss_pkg::t_cell_ctl           i_ctl,
    input  logic [pss_pkg::IDX_W-1:0]    i_index,
    input  logic [pss_pkg::DATA_W-1:0]   i_left,
    input  logic [pss_pkg::DATA_W-1:0]   i_right,
    output logic [pss_pkg::DATA_W-1:0]   o_entry,
    output logic [pss_pkg::DATA_W-1:0]   o_tap
);
    import pss_pkg::*;

    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] n_entry;
    logic              w_hit;
    logic              w_above;

    assign w_hit   = ({1'b0, i_index} == {{(IDX_W + 1 - POS_W){1'b0}}, i_ctl.pos});
    assign w_above = ({1'b0, i_index} >  {{(IDX_W + 1 - POS_W){1'b0}}, i_ctl.pos});

    // Insert moves entries up from the left, remove pulls them down from the right.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && w_above) begin
            n_entry = i_left;
        end else if (i_ctl.ins && w_hit) begin
            n_entry = i_ctl.value;
        end else if (i_ctl.rem && (w_above || w_hit)) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

    // Only the addressed cell puts its entry on the read-back tree.
    assign o_tap = w_hit ? r_entry : '0;

endmodule

// File: src/pss_gather.sv
// OR tree with a registered first level; collects the addressed cell's entry.
`timescale 1ns / 1ps

module pss_gather (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic [pss_pkg::DATA_W-1:0]  i_taps [pss_pkg::CAPACITY],
    output logic [pss_pkg::DATA_W-1:0]  o_data
);
    import pss_pkg::*;

    logic [DATA_W-1:0] r_grp [GRP_NUM];
    logic [DATA_W-1:0] n_grp [GRP_NUM];

    // First level: OR within each group, registered only while a request is worked
    // so the captured entry survives the shift and any wait for the receiver.
    for (genvar g = 0; g < GRP_NUM; g++) begin : g_grp
        always_comb begin
            n_grp[g] = '0;
            for (int j = 0; j < GRP_SIZE; j++) begin
                if (g * GRP_SIZE + j < CAPACITY) begin
                    n_grp[g] = n_grp[g] | i_taps[g * GRP_SIZE + j];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_load) begin
                r_grp[g] <= n_grp[g];
            end
        end
    end

    // Second level: OR of the group registers.
    always_comb begin
        o_data = '0;
        for (int g = 0; g < GRP_NUM; g++) begin
            o_data = o_data | r_grp[g];
        end
    end

endmodule

// File: src/positional_sequence_store.sv
// Top level of the positional sequence store: control, cell chain and read-back.
`timescale 1ns / 1ps
//
// Ordered store of up to CAPACITY signed 32-bit entries kept in a chain of cells.
// Input channel (i_in_valid / o_in_ready) carries one request: a command (read,
// insert or remove), a position and, for insert, a value. Output channel
// (o_out_valid / i_out_ready) returns one result per request: the value read or
// removed, the length after the request and a status (ok, position out of
// range, store full on insert). A failed request leaves the store unchanged.
// A request is taken in the idle state; the next cycle every cell shifts in
// parallel and the addressed entry enters the two-level OR tree, whose first
// level is registered; then, in the done state, the result register is loaded
// as soon as it is free. A new request is taken only after that, back in the
// idle state, so one request is worked at a time; the result passes the request
// register, the tree's group registers and the result register.
// If the receiver stalls, a finished result waits in the output register while
// the next request is accepted and worked; that request then holds in its last
// step until the output register frees. Reset empties the store (length zero)
// and clears all handshake state; entry contents are not cleared.

module positional_sequence_store (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [pss_pkg::CMD_W-1:0]    i_cmd,
    input  logic [pss_pkg::POS_W-1:0]    i_pos,
    input  logic [pss_pkg::DATA_W-1:0]   i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [pss_pkg::DATA_W-1:0]   o_data,
    output logic [pss_pkg::CNT_W-1:0]    o_length,
    output logic [pss_pkg::ST_W-1:0]     o_status
);
    import pss_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [CMD_W-1:0]  r_cmd;
    logic [POS_W-1:0]  r_pos;
    logic [DATA_W-1:0] r_value;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    t_status           r_res_status;
    t_status           n_res_status;
    logic              r_res_take;
    logic              n_res_take;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic [CNT_W-1:0]  r_out_length;
    t_status           r_out_status;
    logic              w_accept;
    logic              w_load_out;
    logic              w_tree_load;
    logic              w_in_range;
    logic              w_ins_range;
    t_cell_ctl         w_ctl;
    logic [DATA_W-1:0] w_entry [CAPACITY];
    logic [DATA_W-1:0] w_tap   [CAPACITY];
    logic [DATA_W-1:0] w_gather;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Request register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_cmd;
            r_pos   <= i_pos;
            r_value <= i_value;
        end
    end

    // Position checks against the current length.
    assign w_in_range  = ({1'b0, r_pos} < {1'b0, r_count});
    assign w_ins_range = ({1'b0, r_pos} <= {1'b0, r_count});

    // Status, cell control and new length for the request being worked.
    always_comb begin
        n_res_status = r_res_status;
        n_res_take   = r_res_take;
        n_count      = r_count;
        w_ctl.ins    = 1'b0;
        w_ctl.rem    = 1'b0;
        w_ctl.pos    = r_pos;
        w_ctl.value  = r_value;
        if (r_state == S_EXEC) begin
            n_res_status = ST_OK;
            n_res_take   = 1'b0;
            unique case (r_cmd)
                CMD_READ: begin
                    if (w_in_range) begin
                        n_res_take = 1'b1;
                    end else begin
                        n_res_status = ST_RANGE;
                    end
                end
                CMD_INSERT: begin
                    if (!w_ins_range) begin
                        n_res_status = ST_RANGE;
                    end else if (r_count == CNT_W'(CAPACITY)) begin
                        n_res_status = ST_FULL;
                    end else begin
                        w_ctl.ins = 1'b1;
                        n_count   = r_count + CNT_W'(1);
                    end
                end
                CMD_REMOVE: begin
                    if (w_in_range) begin
                        n_res_take = 1'b1;
                        w_ctl.rem  = 1'b1;
                        n_count    = r_count - CNT_W'(1);
                    end else begin
                        n_res_status = ST_RANGE;
                    end
                end
                default: begin
                    n_res_status = ST_OK;
                end
            endcase
        end
    end

    // Controller: take request, work it in the chain, then deliver.
    always_comb begin
        n_state    = r_state;
        w_load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The read-back tree captures the addressed entry before the cells shift.
    assign w_tree_load = (r_state == S_EXEC);

    // Output register handshake.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_res_status <= ST_OK;
            r_res_take   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_res_status <= n_res_status;
            r_res_take   <= n_res_take;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data   <= r_res_take ? w_gather : '0;
            r_out_length <= r_count;
            r_out_status <= r_res_status;
        end
    end

    // Chain of cells; the ends see their own entry as the missing neighbor.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;

        if (k == 0) begin : g_first
            assign w_left = w_entry[k];
        end else begin : g_mid_l
            assign w_left = w_entry[k - 1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign w_right = w_entry[k];
        end else begin : g_mid_r
            assign w_right = w_entry[k + 1];
        end

        pss_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_index (IDX_W'(k)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[k]),
            .o_tap   (w_tap[k])
        );
    end

    pss_gather u_gather (
        .i_clk  (i_clk),
        .i_load (w_tree_load),
        .i_taps (w_tap),
        .o_data (w_gather)
    );

    assign o_out_valid = r_out_valid;
    assign o_data      = r_out_data;
    assign o_length    = r_out_length;
    assign o_status    = r_out_status;

endmodule

// File: sim/tb.sv
// Self-checking testbench for the positional sequence store.
`timescale 1ns / 1ps

module tb;
    import pss_pkg::*;

    // The command code that the block must treat as a no-op.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [POS_W-1:0] POS_MAX    = '1;
    localparam int CHUNK_ITEMS      = 120;
    localparam int CHUNK_NUM        = 12;
    localparam int LONG_HOLD_AT     = 600;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES      = 20;
    localparam int CYCLE_LIMIT      = 800000;

    typedef enum int {
        PH_GROW,
        PH_MIXED,
        PH_SHRINK
    } list_phase_t;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
        bit                drain;
    } list_req_t;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  length;
        t_status           status;
    } list_reply_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [CMD_W-1:0]  i_cmd;
    logic [POS_W-1:0]  i_pos;
    logic [DATA_W-1:0] i_value;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [DATA_W-1:0] o_data;
    logic [CNT_W-1:0]  o_length;
    logic [ST_W-1:0]   o_status;

    // Shadow copy of the sequence as the block should hold it.
    logic [DATA_W-1:0] list_mem [CAPACITY];
    int                list_len = 0;

    list_req_t   request_queue [$];
    list_reply_t list_replies [$];

    int presented_cnt = 0;
    int accepted_cnt  = 0;
    int fail_cnt      = 0;
    int cycle_cnt     = 0;
    int plan_len      = 0;

    int tx_gap  = 0;
    int tx_calm = 0;
    int rx_hold = 0;
    int rx_calm = 0;
    bit long_hold_done = 0;

    positional_sequence_store uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_pos       (i_pos),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data      (o_data),
        .o_length    (o_length),
        .o_status    (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Apply one request to the shadow sequence and return the result it must produce.
    function automatic list_reply_t apply_to_list(logic [CMD_W-1:0] cmd,
                                                  logic [POS_W-1:0] pos,
                                                  logic [DATA_W-1:0] value);
        list_reply_t r;
        int          i;
        r.data   = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_READ: begin
                if (pos < list_len) r.data = list_mem[pos];
                else r.status = ST_RANGE;
            end
            CMD_INSERT: begin
                if (pos > list_len) begin
                    r.status = ST_RANGE;
                end else if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
                    list_mem[pos] = value;
                    list_len++;
                end
            end
            CMD_REMOVE: begin
                if (pos < list_len) begin
                    r.data = list_mem[pos];
                    for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                end else begin
                    r.status = ST_RANGE;
                end
            end
            default: ;
        endcase
        r.length = list_len[CNT_W-1:0];
        return r;
    endfunction

    // Short gaps mostly, now and then a long one.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd(list_phase_t ph);
        int r;
        r = $urandom_range(0, 99);
        case (ph)
            PH_GROW: begin
                if (r < 70) return CMD_INSERT;
                if (r < 85) return CMD_READ;
                return CMD_REMOVE;
            end
            PH_SHRINK: begin
                if (r < 70) return CMD_REMOVE;
                if (r < 85) return CMD_READ;
                return CMD_INSERT;
            end
            default: begin
                if (r < 34) return CMD_INSERT;
                if (r < 67) return CMD_READ;
                return CMD_REMOVE;
            end
        endcase
    endfunction

    // Queue a request and track the length it leaves behind, so later positions can be aimed.
    task automatic queue_req(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                             logic [DATA_W-1:0] value, bit drain);
        list_req_t q;
        q.cmd   = cmd;
        q.pos   = pos;
        q.value = value;
        q.drain = drain;
        request_queue.push_back(q);
        if (cmd == CMD_INSERT && pos <= plan_len && plan_len < CAPACITY) plan_len++;
        else if (cmd == CMD_REMOVE && pos < plan_len) plan_len--;
    endtask

    // Stimulus, reset and end of run.
    initial begin : main_flow
        int               chunk;
        int               k;
        int               r;
        int               p;
        logic [CMD_W-1:0] c;
        list_phase_t      phase;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_out_ready = 1'b0;
        i_cmd       = '0;
        i_pos       = '0;
        i_value     = '0;

        // Directed requests: empty store, both ends, extreme values and out-of-range positions.
        queue_req(CMD_READ,   0, $urandom, 0);
        queue_req(CMD_REMOVE, 0, $urandom, 0);
        queue_req(CMD_INSERT, 1, 32'h1234_5678, 0);
        queue_req(CMD_UNUSED, 0, $urandom, 0);
        queue_req(CMD_INSERT, 0, 32'h8000_0000, 0);
        queue_req(CMD_INSERT, 1, 32'h7FFF_FFFF, 0);
        queue_req(CMD_INSERT, 0, 32'hFFFF_FFFF, 0);
        queue_req(CMD_INSERT, 1, 32'h0000_0000, 0);
        queue_req(CMD_INSERT, 4, 32'h0000_0001, 0);
        queue_req(CMD_INSERT, 6, 32'h0000_0005, 0);
        queue_req(CMD_READ,   0, $urandom, 0);
        queue_req(CMD_READ,   4, $urandom, 0);
        queue_req(CMD_READ,   5, $urandom, 0);
        queue_req(CMD_READ,   POS_MAX, $urandom, 0);
        queue_req(CMD_INSERT, POS_MAX, $urandom, 0);
        queue_req(CMD_REMOVE, POS_MAX, $urandom, 0);
        queue_req(CMD_REMOVE, 2, $urandom, 0);
        queue_req(CMD_REMOVE, 3, $urandom, 0);
        queue_req(CMD_REMOVE, 0, $urandom, 0);
        queue_req(CMD_UNUSED, POS_MAX, 32'hFFFF_FFFF, 0);
        queue_req(CMD_READ,   1, $urandom, 0);
        queue_req(CMD_REMOVE, 1, $urandom, 0);
        queue_req(CMD_REMOVE, 0, $urandom, 0);
        queue_req(CMD_READ,   0, $urandom, 0);

        // Random chunks alternate between filling, churning and emptying the store.
        // The first request of each chunk waits until the block has drained.
        for (chunk = 0; chunk < CHUNK_NUM; chunk++) begin
            phase = list_phase_t'(chunk % 3);
            for (k = 0; k < CHUNK_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    c = CMD_W'($urandom_range(0, 3));
                    p = $urandom_range(0, POS_MAX);
                end else if (r < 18) begin
                    c = CMD_W'($urandom_range(0, 2));
                    p = plan_len + $urandom_range(0, 1);
                end else begin
                    c = pick_cmd(phase);
                    if (c == CMD_INSERT) p = $urandom_range(0, plan_len);
                    else if (plan_len > 0) p = $urandom_range(0, plan_len - 1);
                    else p = 0;
                end
                queue_req(c, p[POS_W-1:0], pick_value(), k == 0);
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to be taken and answered, then let the pipeline settle.
        while (request_queue.size() > 0 || presented_cnt != accepted_cnt ||
               list_replies.size() > 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_cnt == 0 && list_replies.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Request driver: presents queued requests at the falling edge with random gaps.
    always @(negedge i_clk) begin : drive_requests
        list_req_t q;
        if (i_rst_n && presented_cnt == accepted_cnt) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_in_valid <= 1'b0;
            end else if (request_queue.size() > 0 &&
                         !(request_queue[0].drain && list_replies.size() != 0)) begin
                q = request_queue.pop_front();
                i_in_valid <= 1'b1;
                i_cmd      <= q.cmd;
                i_pos      <= q.pos;
                i_value    <= q.value;
                presented_cnt++;
                if (tx_calm > 0) begin
                    tx_calm--;
                    tx_gap = 0;
                end else begin
                    tx_gap = draw_gap();
                    if ($urandom_range(0, 199) == 0) tx_calm = $urandom_range(30, 80);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random back-pressure plus one long hold-off that fills the block.
    always @(negedge i_clk) begin : drive_ready
        if (i_rst_n) begin
            if (!long_hold_done && accepted_cnt >= LONG_HOLD_AT) begin
                rx_hold = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (rx_calm > 0) begin
                    rx_calm--;
                end else begin
                    if ($urandom_range(0, 3) == 0) rx_hold = draw_gap();
                    if ($urandom_range(0, 199) == 0) rx_calm = $urandom_range(30, 80);
                end
            end
        end
    end

    // Monitor: predicts each accepted request, then checks each accepted result in order.
    always @(posedge i_clk) begin : watch_channels
        list_reply_t want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                list_replies.push_back(apply_to_list(i_cmd, i_pos, i_value));
                accepted_cnt++;
            end
            if (o_out_valid && i_out_ready) begin
                if (list_replies.size() == 0) begin
                    $error("result with no request pending: data %0d, length %0d, status %0d",
                           $signed(o_data), o_length, o_status);
                    fail_cnt++;
                end else begin
                    want = list_replies.pop_front();
                    if (o_data !== want.data) begin
                        $error("data mismatch: expected %0d, got %0d",
                               $signed(want.data), $signed(o_data));
                        fail_cnt++;
                    end
                    if (o_length !== want.length) begin
                        $error("length mismatch: expected %0d, got %0d",
                               want.length, o_length);
                        fail_cnt++;
                    end
                    if (o_status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, o_status);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin : watchdog
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
